@@ rtl/core/pll_divider_search_macros.svh @@
// assertion macros for the pll divider search block
// expects clk and arst_n in the scope of every use
`ifndef PLL_DIVIDER_SEARCH_MACROS_SVH
`define PLL_DIVIDER_SEARCH_MACROS_SVH
`ifndef SYNTHESIS
`define PDS_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("pll divider search: same-cycle check failed");
`define PDS_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("pll divider search: next-cycle check failed");
`else
`define PDS_ASSERT_IMP(lbl, ante, cons)
`define PDS_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

@@ rtl/core/pds_pkg.sv @@
// package for the pll divider search block: types, constants, band tables
// no dependencies
`timescale 1ns / 1ps
package pds_pkg;

	localparam int PDS_W             = 72;
	localparam int PDS_MAX_REF_DIV   = 511;
	localparam int PDS_RATE_BITS     = 32;

	localparam logic [63:0] F_1G     = 64'd1000000000;
	localparam logic [63:0] F_3G     = 64'd3000000000;
	localparam logic [63:0] F_4G     = 64'd4000000000;
	localparam logic [63:0] F_32M1   = 64'd32000001;
	localparam logic [63:0] F_8M     = 64'd8000000;
	localparam logic [63:0] F_100M   = 64'd100000000;
	localparam logic [63:0] F_5M     = 64'd5000000;
	localparam int          OM_SHIFT = 20;

	typedef enum logic {
		OP_MUL,
		OP_DIV
	} arith_op_t;

	typedef struct packed {
		logic      start;
		arith_op_t op;
	} arith_req_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_VDESK,
		ST_VDIV,
		ST_FVCO,
		ST_R0,
		ST_FREF,
		ST_FB_MUL,
		ST_FB_DIV,
		ST_NUM,
		ST_DEN,
		ST_CALC,
		ST_FIN,
		ST_FIN_MUL,
		ST_FIN_DIV,
		ST_OFF_MUL,
		ST_OFF_DIV,
		ST_OM_DIV,
		ST_DONE
	} pds_state_t;

	function automatic logic [3:0] band_of(input logic [31:0] f);
		logic [63:0] x;
		x = 64'(f);
		if (x < 64'd1200000000)      band_of = 4'd0;
		else if (x < 64'd1350000000) band_of = 4'd8;
		else if (x < 64'd1500000000) band_of = 4'd9;
		else if (x < 64'd1750000000) band_of = 4'd10;
		else if (x < 64'd2000000000) band_of = 4'd11;
		else if (x < 64'd2200000000) band_of = 4'd12;
		else if (x < 64'd2400000000) band_of = 4'd13;
		else if (x < 64'd2600000000) band_of = 4'd14;
		else if (x < 64'd3000000000) band_of = 4'd15;
		else                         band_of = 4'd0;
	endfunction

	// {bandwidth select, pump current}
	function automatic logic [3:0] pump_of(input logic [31:0] f);
		if (f < 32'd8000000)       pump_of = 4'd0;
		else if (f < 32'd9000000)  pump_of = 4'd3;
		else if (f < 32'd11000000) pump_of = 4'd2;
		else if (f < 32'd13000000) pump_of = 4'd1;
		else if (f < 32'd16000000) pump_of = 4'd0;
		else if (f < 32'd18000000) pump_of = 4'd15;
		else if (f < 32'd22000000) pump_of = 4'd14;
		else if (f < 32'd26000000) pump_of = 4'd13;
		else if (f < 32'd32000000) pump_of = 4'd12;
		else                       pump_of = 4'd0;
	endfunction

endpackage

@@ rtl/core/pds_arith.sv @@
// shared multicycle arithmetic unit: shift-add multiply, restoring divide
// depends on pds_pkg and pll_divider_search_macros.svh
`timescale 1ns / 1ps
`include "pll_divider_search_macros.svh"
module pds_arith
	import pds_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  arith_req_t       req,
	input  logic [PDS_W-1:0] a,
	input  logic [PDS_W-1:0] b,
	output logic [PDS_W-1:0] res,
	output logic             done
);

	localparam int CW = $clog2(PDS_W + 1);

	logic             busy_q, done_q;
	arith_op_t        op_q;
	logic [PDS_W-1:0] acc_q, x_q, y_q, rem_q;
	logic [CW-1:0]    cnt_q;
	logic [PDS_W:0]   rem2;
	logic             ge;

	assign rem2 = {rem_q, x_q[PDS_W-1]};
	assign ge   = rem2 >= {1'b0, y_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
			end else if (busy_q) begin
				if (op_q == OP_MUL) begin
					if (y_q == '0) begin
						busy_q <= 1'b0;
						done_q <= 1'b1;
					end
				end else if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			op_q  <= req.op;
			acc_q <= '0;
			x_q   <= a;
			y_q   <= b;
			rem_q <= '0;
			cnt_q <= CW'(PDS_W);
		end else if (busy_q) begin
			if (op_q == OP_MUL) begin
				if (y_q != '0) begin
					if (y_q[0]) acc_q <= acc_q + x_q;
					x_q <= {x_q[PDS_W-2:0], 1'b0};
					y_q <= {1'b0, y_q[PDS_W-1:1]};
				end
			end else begin
				rem_q <= ge ? PDS_W'(rem2 - {1'b0, y_q}) : rem2[PDS_W-1:0];
				x_q   <= {x_q[PDS_W-2:0], ge};
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

	assign res  = (op_q == OP_MUL) ? acc_q : x_q;
	assign done = done_q;

	`PDS_ASSERT_IMP(a_start_when_free, req.start, !busy_q)
	`PDS_ASSERT_NEXT(a_start_goes_busy, req.start, busy_q)
	`PDS_ASSERT_IMP(a_done_is_free, done_q, !busy_q)

endmodule

@@ rtl/core/pll_divider_search.sv @@
// top level of the pll divider search: sequencer, datapath registers, result word
// depends on pds_pkg, pds_arith and pll_divider_search_macros.svh
`timescale 1ns / 1ps
//
// usage
//   command word: target_rate and reference_rate, taken at a clock edge with start
//   high and busy low. busy stays high while the search runs.
//   result word: all ports are shown in the single cycle marked by done; the
//   receiver cannot stall it, so it must take the word in that cycle. result
//   ports keep their values until the next done.
//   config: cfg_we writes cfg_wdata into deskew_mode; write only while idle.
// search
//   every step runs on one shared shift-add multiplier / restoring divider.
//   each reference divider candidate costs two to three divides and two to
//   three multiplies; a full walk covers up to MAX_REF_DIVIDER candidates.
//   an invalid target goes from idle straight to done; one word at a time.
// reset
//   arst_n clears the sequencer and deskew_mode; no result is shown after reset.
//
module pll_divider_search
	import pds_pkg::*;
#(
	parameter int MAX_REF_DIVIDER = PDS_MAX_REF_DIV,
	parameter int RATE_BITS       = PDS_RATE_BITS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_wdata,
	input  logic        start,
	output logic        busy,
	input  logic [31:0] target_rate,
	input  logic [31:0] reference_rate,
	output logic        done,
	output logic [8:0]  ref_divider,
	output logic [8:0]  feedback_divider,
	output logic [2:0]  post_div_select,
	output logic [3:0]  vco_band,
	output logic [2:0]  pump_current,
	output logic        bandwidth_select,
	output logic [16:0] freq_offset_code,
	output logic [31:0] achieved_rate,
	output logic [31:0] rounded_rate,
	output logic        request_invalid
);

	localparam int              RW       = $clog2(MAX_REF_DIVIDER + 1);
	localparam logic [RW-1:0]   RMAX     = RW'(MAX_REF_DIVIDER);
	localparam logic [31:0]     RATE_MAX = 32'((64'd1 << RATE_BITS) - 64'd1);

	pds_state_t       state_q, state_d;
	logic             issued_q, dk_q, done_q;
	arith_req_t       req;
	logic [PDS_W-1:0] op_a, op_b, ar_res;
	logic             ar_done;

	// search registers
	logic [31:0]      rate_q, p_q, fvco_q, fref_q, fb_q, best_fb_q, best_fref_q;
	logic [32:0]      v_q, t_q;
	logic [RW-1:0]    r_q, best_r_q;
	logic             first_q, inv_q, pos_q;
	logic [PDS_W-1:0] num_q, den_q, best_calc_q, best_diff_q;
	logic [31:0]      ach_q, rounded_q, mag_q;
	logic [16:0]      code_q;

	logic [31:0]      rate_in, p_in;
	logic             invalid_in;
	logic [PDS_W-1:0] rate_w, cdiff, ach_sat_src;
	logic [31:0]      best_sat, fin_sat, ach_fvco_diff;
	logic             better, mag_over;
	logic [PDS_W-1:0] om_div;
	logic [2:0]       post_sel;
	logic [3:0]       pump_bw;

	assign rate_in    = target_rate & RATE_MAX;
	assign p_in       = reference_rate & RATE_MAX;
	assign invalid_in = (rate_in == '0) || (64'(rate_in) > F_4G);
	assign rate_w     = PDS_W'(rate_q);
	assign busy       = (state_q != ST_IDLE);

	// distance of a candidate rate from the target
	assign cdiff  = (ar_res > rate_w) ? ar_res - rate_w : rate_w - ar_res;
	assign better = first_q || (best_diff_q > cdiff);

	assign best_sat    = (best_calc_q > PDS_W'(RATE_MAX)) ? RATE_MAX : best_calc_q[31:0];
	assign ach_sat_src = ar_res;
	assign fin_sat     = (ach_sat_src > PDS_W'(RATE_MAX)) ? RATE_MAX : ach_sat_src[31:0];

	assign ach_fvco_diff = (ach_q > fvco_q) ? ach_q - fvco_q : fvco_q - ach_q;
	// minus one hundred percent, or a magnitude beyond one hundred percent, saturates the offset code
	assign mag_over = (ar_res > PDS_W'(F_100M)) || (!pos_q && ar_res == PDS_W'(F_100M));
	assign om_div   = pos_q ? PDS_W'(F_100M) + PDS_W'(mag_q)
	                        : PDS_W'(F_100M) - PDS_W'(mag_q);

	always_comb begin
		post_sel = 3'd0;
		for (int i = 0; i < 8; i++) begin
			if (v_q == 33'(1 << i)) post_sel = 3'(i);
		end
	end
	assign pump_bw = pump_of(best_fref_q);

	// sequencer: next state and shared unit requests
	always_comb begin
		state_d   = state_q;
		req.start = 1'b0;
		req.op    = OP_MUL;
		op_a      = '0;
		op_b      = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					if (invalid_in)             state_d = ST_DONE;
					else if (dk_q)              state_d = ST_VDESK;
					else if (64'(rate_in) < F_1G) state_d = ST_VDIV;
					else                        state_d = ST_FVCO;
				end
			end
			ST_VDESK: begin
				if (64'(t_q) > F_3G) state_d = ST_FVCO;
			end
			ST_VDIV: begin
				req.op = OP_DIV;
				op_a   = PDS_W'(F_1G) + rate_w - PDS_W'(1);
				op_b   = rate_w;
				if (ar_done) state_d = ST_FVCO;
			end
			ST_FVCO: begin
				req.op = OP_MUL;
				op_a   = rate_w;
				op_b   = PDS_W'(v_q);
				if (ar_done) state_d = ST_R0;
			end
			ST_R0: begin
				req.op = OP_DIV;
				op_a   = PDS_W'(p_q);
				op_b   = PDS_W'(F_32M1);
				if (ar_done) state_d = ST_FREF;
			end
			ST_FREF: begin
				req.op = OP_DIV;
				op_a   = PDS_W'(p_q);
				op_b   = PDS_W'(r_q);
				if (ar_done) begin
					if (!first_q && ar_res < PDS_W'(F_8M)) state_d = ST_FIN;
					else if (ar_res == '0)                 state_d = ST_NUM;
					else if (dk_q)                         state_d = ST_FB_MUL;
					else                                   state_d = ST_FB_DIV;
				end
			end
			ST_FB_MUL: begin
				req.op = OP_MUL;
				op_a   = PDS_W'(fref_q);
				op_b   = PDS_W'(v_q);
				if (ar_done) state_d = ST_FB_DIV;
			end
			ST_FB_DIV: begin
				req.op = OP_DIV;
				op_a   = dk_q ? PDS_W'(fvco_q) : PDS_W'(fvco_q[31:2]);
				op_b   = dk_q ? den_q : PDS_W'(fref_q);
				if (ar_done) state_d = ST_NUM;
			end
			ST_NUM: begin
				req.op = OP_MUL;
				op_a   = PDS_W'(p_q);
				op_b   = PDS_W'(fb_q);
				if (ar_done) state_d = ST_DEN;
			end
			ST_DEN: begin
				req.op = OP_MUL;
				op_a   = PDS_W'(r_q);
				op_b   = PDS_W'(v_q);
				if (ar_done) state_d = ST_CALC;
			end
			ST_CALC: begin
				req.op = OP_DIV;
				op_a   = num_q;
				op_b   = den_q;
				if (ar_done) state_d = (r_q == RMAX) ? ST_FIN : ST_FREF;
			end
			ST_FIN: begin
				if (dk_q)                  state_d = ST_FIN_MUL;
				else if (best_sat != rate_q) state_d = ST_OFF_MUL;
				else                       state_d = ST_DONE;
			end
			ST_FIN_MUL: begin
				req.op = OP_MUL;
				op_a   = PDS_W'(p_q);
				op_b   = PDS_W'(best_fb_q);
				if (ar_done) state_d = ST_FIN_DIV;
			end
			ST_FIN_DIV: begin
				req.op = OP_DIV;
				op_a   = num_q;
				op_b   = PDS_W'(best_r_q);
				if (ar_done) state_d = ST_DONE;
			end
			ST_OFF_MUL: begin
				req.op = OP_MUL;
				op_a   = PDS_W'(ach_fvco_diff);
				op_b   = PDS_W'(F_100M);
				if (ar_done) state_d = ST_OFF_DIV;
			end
			ST_OFF_DIV: begin
				req.op = OP_DIV;
				op_a   = num_q;
				op_b   = PDS_W'(fvco_q);
				if (ar_done) state_d = mag_over ? ST_DONE : ST_OM_DIV;
			end
			ST_OM_DIV: begin
				req.op = OP_DIV;
				op_a   = PDS_W'(mag_q) << OM_SHIFT;
				op_b   = om_div;
				if (ar_done) state_d = ST_DONE;
			end
			ST_DONE: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
		// unit states issue their operation once on entry
		if (state_q != ST_IDLE && state_q != ST_VDESK && state_q != ST_FIN &&
		    state_q != ST_DONE && !issued_q) begin
			req.start = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			issued_q <= 1'b0;
			dk_q     <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			state_q  <= state_d;
			done_q   <= (state_q == ST_DONE);
			if (req.start)    issued_q <= 1'b1;
			else if (ar_done) issued_q <= 1'b0;
			if (cfg_we) dk_q <= cfg_wdata;
		end
	end

	// datapath captures
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					rate_q    <= rate_in;
					p_q       <= p_in;
					inv_q     <= invalid_in;
					v_q       <= 33'd1;
					t_q       <= 33'(rate_in);
					code_q    <= '0;
					first_q   <= 1'b1;
				end
			end
			ST_VDESK: begin
				if (64'(t_q) > F_3G) begin
					v_q <= (v_q[32:1] == '0) ? 33'd1 : {1'b0, v_q[32:1]};
				end else begin
					v_q <= {v_q[31:0], 1'b0};
					t_q <= {t_q[31:0], 1'b0};
				end
			end
			ST_VDIV: if (ar_done) v_q <= ar_res[32:0];
			ST_FVCO: if (ar_done) fvco_q <= ar_res[31:0];
			ST_R0: begin
				if (ar_done) begin
					r_q <= (ar_res >= PDS_W'(RMAX)) ? RMAX : RW'(ar_res + PDS_W'(1));
				end
			end
			ST_FREF: begin
				if (ar_done) begin
					fref_q <= ar_res[31:0];
					if (ar_res == '0) fb_q <= '0;
				end
			end
			ST_FB_MUL: if (ar_done) den_q <= ar_res;
			ST_FB_DIV: if (ar_done) fb_q <= ar_res[31:0];
			ST_NUM: begin
				if (ar_done) num_q <= dk_q ? ar_res : {ar_res[PDS_W-3:0], 2'b00};
			end
			ST_DEN: if (ar_done) den_q <= ar_res;
			ST_CALC: begin
				if (ar_done) begin
					if (better) begin
						best_r_q    <= r_q;
						best_calc_q <= ar_res;
						best_diff_q <= cdiff;
						best_fb_q   <= fb_q;
						best_fref_q <= fref_q;
					end
					first_q <= 1'b0;
					if (r_q != RMAX) r_q <= r_q + RW'(1);
				end
			end
			ST_FIN: begin
				ach_q     <= best_sat;
				rounded_q <= best_sat;
			end
			ST_FIN_MUL: if (ar_done) num_q <= ar_res;
			ST_FIN_DIV: begin
				if (ar_done) begin
					ach_q     <= fin_sat;
					rounded_q <= fin_sat;
				end
			end
			ST_OFF_MUL: begin
				if (ar_done) begin
					num_q <= ar_res;
					pos_q <= ach_q > fvco_q;
				end
			end
			ST_OFF_DIV: begin
				if (ar_done) begin
					mag_q  <= ar_res[31:0];
					code_q <= {!pos_q, 16'hffff};
					if (ar_res <= PDS_W'(F_5M)) rounded_q <= rate_q;
				end
			end
			ST_OM_DIV: if (ar_done) code_q <= {!pos_q, ar_res[15:0]};
			ST_DONE: begin
				request_invalid  <= inv_q;
				ref_divider      <= inv_q ? '0 : 9'(best_r_q);
				feedback_divider <= inv_q ? '0 : best_fb_q[8:0];
				post_div_select  <= inv_q ? '0 : post_sel;
				vco_band         <= inv_q ? '0 : band_of(fvco_q);
				pump_current     <= inv_q ? '0 : pump_bw[2:0];
				bandwidth_select <= inv_q ? 1'b0 : pump_bw[3];
				freq_offset_code <= inv_q ? '0 : code_q;
				achieved_rate    <= inv_q ? '0 : ach_q;
				rounded_rate     <= inv_q ? '0 : rounded_q;
			end
			default: begin
			end
		endcase
	end

	assign done = done_q;

	pds_arith u_arith (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.a      (op_a),
		.b      (op_b),
		.res    (ar_res),
		.done   (ar_done)
	);

	`PDS_ASSERT_NEXT(a_accept_goes_busy, start && !busy, busy)
	`PDS_ASSERT_IMP(a_done_when_idle, done, !busy)
	`PDS_ASSERT_IMP(a_invalid_zeroed, done && request_invalid, achieved_rate == '0 && ref_divider == '0)

endmodule

@@ bench/tb_pll_divider_search.sv @@
// self-checking bench for pll_divider_search: directed and random rate requests
// in both divider modes, predicted results checked word by word
// depends on pds_pkg and the pll_divider_search rtl
`timescale 1ns / 1ps
module tb_pll_divider_search;
	import pds_pkg::*;

	localparam logic [63:0] RATE_LIMIT  = 64'd4000000000;
	localparam int unsigned STALL_LIMIT = 600000;
	localparam int          NUM_RANDOM  = 114;

	// one result word as the block presents it
	typedef struct {
		logic [8:0]  ref_div;
		logic [8:0]  fb_div;
		logic [2:0]  post_sel;
		logic [3:0]  band;
		logic [2:0]  icp;
		logic        bw;
		logic [16:0] offset;
		logic [31:0] achieved;
		logic [31:0] rounded;
		logic        invalid;
	} pll_setting_t;

	// expected pll settings, oldest first, with its own copy of deskew_mode
	class pll_setting_board;
		pll_setting_t pending[$];
		bit           deskew;
		int unsigned  errors;

		function logic [63:0] diff(input logic [63:0] a, input logic [63:0] b);
			return (a > b) ? a - b : b - a;
		endfunction

		// feedback divider for a divided reference
		function logic [63:0] feedback_for(input logic [63:0] fvco, input logic [63:0] fref,
				input logic [63:0] v);
			if (fref == 0)
				return 0;
			return deskew ? fvco / (fref * v) : (fvco / 4) / fref;
		endfunction

		// output rate the search compares, products at full width
		function logic [63:0] rate_for(input logic [63:0] p, input logic [63:0] fb,
				input logic [63:0] r, input logic [63:0] v, input bit dk);
			logic [127:0] num;
			num = dk ? 128'(p) * fb : 128'(p) * 4 * fb;
			return 64'(num / (128'(r) * v));
		endfunction

		function pll_setting_t settings_for(input logic [31:0] target, input logic [31:0] refclk);
			pll_setting_t s;
			logic [63:0] rate, p, v, fvco, r, best_r, best_calc, c, fref, fb, ach, mag, dv, om;
			logic [127:0] wide;
			bit pos;
			s = '{default: 0};
			rate = 64'(target);
			p = 64'(refclk);
			if (rate == 0 || rate > RATE_LIMIT) begin
				s.invalid = 1;
				return s;
			end
			// vco divider
			if (deskew) begin
				v = 1;
				while (rate * v <= 64'd3000000000)
					v = v << 1;
				v = v >> 1;
				if (v == 0)
					v = 1;
			end else if (rate < 64'd1000000000) begin
				v = (64'd1000000000 + rate - 1) / rate;
			end else begin
				v = 1;
			end
			for (int i = 0; i < 8; i++)
				if (v == (64'd1 << i))
					s.post_sel = 3'(i);
			fvco = rate * v;
			if (fvco >= 64'd1200000000 && fvco < 64'd1350000000) s.band = 8;
			else if (fvco >= 64'd1350000000 && fvco < 64'd1500000000) s.band = 9;
			else if (fvco >= 64'd1500000000 && fvco < 64'd1750000000) s.band = 10;
			else if (fvco >= 64'd1750000000 && fvco < 64'd2000000000) s.band = 11;
			else if (fvco >= 64'd2000000000 && fvco < 64'd2200000000) s.band = 12;
			else if (fvco >= 64'd2200000000 && fvco < 64'd2400000000) s.band = 13;
			else if (fvco >= 64'd2400000000 && fvco < 64'd2600000000) s.band = 14;
			else if (fvco >= 64'd2600000000 && fvco < 64'd3000000000) s.band = 15;
			// walk reference dividers, earliest wins a tie
			r = p / 64'd32000001 + 1;
			if (r > PDS_MAX_REF_DIV)
				r = PDS_MAX_REF_DIV;
			best_r = r;
			best_calc = rate_for(p, feedback_for(fvco, p / r, v), r, v, deskew);
			for (r = r + 1; r <= PDS_MAX_REF_DIV && p / r >= 64'd8000000; r++) begin
				c = rate_for(p, feedback_for(fvco, p / r, v), r, v, deskew);
				if (diff(best_calc, rate) > diff(c, rate)) begin
					best_r = r;
					best_calc = c;
				end
			end
			fref = p / best_r;
			fb = feedback_for(fvco, fref, v);
			if (deskew) begin
				wide = 128'(p) * fb / best_r;
				ach = (wide > 128'hffffffff) ? 64'hffffffff : 64'(wide);
			end else begin
				ach = rate_for(p, fb, best_r, v, 0);
			end
			if (ach > 64'hffffffff)
				ach = 64'hffffffff;
			s.rounded = ach[31:0];
			if (fref >= 8000000 && fref < 9000000) s.icp = 3;
			else if (fref >= 9000000 && fref < 11000000) s.icp = 2;
			else if (fref >= 11000000 && fref < 13000000) s.icp = 1;
			else if (fref >= 13000000 && fref < 16000000) s.icp = 0;
			else if (fref >= 16000000 && fref < 18000000) {s.bw, s.icp} = {1'b1, 3'd7};
			else if (fref >= 18000000 && fref < 22000000) {s.bw, s.icp} = {1'b1, 3'd6};
			else if (fref >= 22000000 && fref < 26000000) {s.bw, s.icp} = {1'b1, 3'd5};
			else if (fref >= 26000000 && fref < 32000000) {s.bw, s.icp} = {1'b1, 3'd4};
			// frequency offset, normal mode only
			if (!deskew && ach != rate) begin
				pos = ach > fvco;
				mag = diff(ach, fvco) * 64'd100000000 / fvco;
				dv = pos ? 64'd100000000 + mag : 64'd100000000 - mag;
				if (dv == 0 || mag > 64'd100000000)
					om = 64'hffff;
				else
					om = ((mag * 64'd1048576) / dv) & 64'hffff;
				s.offset = {~pos, om[15:0]};
				if (mag <= 64'd5000000)
					s.rounded = target;
			end
			s.ref_div = best_r[8:0];
			s.fb_div = fb[8:0];
			s.achieved = ach[31:0];
			return s;
		endfunction

		function void note_request(input logic [31:0] target, input logic [31:0] refclk);
			pending.push_back(settings_for(target, refclk));
		endfunction

		task report(input string what, input logic [31:0] got, input logic [31:0] want);
			$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
			errors++;
		endtask

		task check_result(input pll_setting_t g);
			pll_setting_t e;
			if (pending.size() == 0) begin
				$display("mismatch: result word with nothing pending at %0t", $realtime);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (g.ref_div !== e.ref_div)
				report("ref_divider", 32'(g.ref_div), 32'(e.ref_div));
			if (g.fb_div !== e.fb_div)
				report("feedback_divider", 32'(g.fb_div), 32'(e.fb_div));
			if (g.post_sel !== e.post_sel)
				report("post_div_select", 32'(g.post_sel), 32'(e.post_sel));
			if (g.band !== e.band) report("vco_band", 32'(g.band), 32'(e.band));
			if (g.icp !== e.icp) report("pump_current", 32'(g.icp), 32'(e.icp));
			if (g.bw !== e.bw) report("bandwidth_select", 32'(g.bw), 32'(e.bw));
			if (g.offset !== e.offset)
				report("freq_offset_code", 32'(g.offset), 32'(e.offset));
			if (g.achieved !== e.achieved) report("achieved_rate", g.achieved, e.achieved);
			if (g.rounded !== e.rounded) report("rounded_rate", g.rounded, e.rounded);
			if (g.invalid !== e.invalid)
				report("request_invalid", 32'(g.invalid), 32'(e.invalid));
		endtask
	endclass

	logic        clk = 0;
	logic        arst_n = 0;
	logic        cfg_we = 0;
	logic        cfg_wdata = 0;
	logic        start = 0;
	logic        busy;
	logic [31:0] target_rate = 0;
	logic [31:0] reference_rate = 0;
	logic        done;
	logic [8:0]  ref_divider;
	logic [8:0]  feedback_divider;
	logic [2:0]  post_div_select;
	logic [3:0]  vco_band;
	logic [2:0]  pump_current;
	logic        bandwidth_select;
	logic [16:0] freq_offset_code;
	logic [31:0] achieved_rate;
	logic [31:0] rounded_rate;
	logic        request_invalid;

	pll_setting_board board = new();
	int unsigned      quiet_cycles = 0;
	int unsigned      burst_left = 0;

	pll_divider_search DUT (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.start(start), .busy(busy), .target_rate(target_rate),
		.reference_rate(reference_rate), .done(done), .ref_divider(ref_divider),
		.feedback_divider(feedback_divider), .post_div_select(post_div_select),
		.vco_band(vco_band), .pump_current(pump_current),
		.bandwidth_select(bandwidth_select), .freq_offset_code(freq_offset_code),
		.achieved_rate(achieved_rate), .rounded_rate(rounded_rate),
		.request_invalid(request_invalid)
	);

	// 8 ns clock
	always begin
		#4 clk = 1;
		#4 clk = 0;
	end

	// result words are taken in their single done cycle; the bench never stalls
	always @(posedge clk) begin
		if (arst_n && done)
			board.check_result('{ref_divider, feedback_divider, post_div_select, vco_band,
				pump_current, bandwidth_select, freq_offset_code, achieved_rate,
				rounded_rate, request_invalid});
	end

	// watchdog: cycles with neither a command nor a result word accepted
	always @(posedge clk) begin
		if ((start && !busy) || done)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// one command word; start stays high inside a burst, may drop for a gap after it
	task send_request(input logic [31:0] target, input logic [31:0] refclk);
		int unsigned gap;
		@(negedge clk);
		start <= 1;
		target_rate <= target;
		reference_rate <= refclk;
		while (busy)
			@(negedge clk);
		// no busy in this cycle, so the coming edge takes the word
		@(posedge clk);
		board.note_request(target, refclk);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 6);
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 20);
			if (gap != 0) begin
				@(negedge clk);
				start <= 0;
				repeat (gap - 1) @(negedge clk);
			end
		end else begin
			burst_left--;
		end
	endtask

	// drain, let the sequencer settle, then write the mode while idle
	task set_deskew(input bit mode);
		@(negedge clk);
		start <= 0;
		while (board.pending.size() != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
		cfg_we <= 1;
		cfg_wdata <= mode;
		@(negedge clk);
		cfg_we <= 0;
		board.deskew = mode;
	endtask

	// mostly short walks; a few full-width references for the long searches
	function logic [31:0] pick_reference(inout int unsigned wide_left);
		int unsigned sel;
		sel = $urandom_range(0, 99);
		if (sel < 3 && wide_left > 0) begin
			wide_left--;
			return $urandom;
		end
		if (sel < 20)
			return $urandom_range(0, 400000000);
		if (sel < 30)
			return $urandom_range(0, 8000000);
		return $urandom_range(8000000, 100000000);
	endfunction

	function logic [31:0] pick_target();
		int unsigned sel;
		sel = $urandom_range(0, 99);
		if (sel < 8)
			return $urandom;           // all bits, invalid ones among them
		if (sel < 40)
			return $urandom_range(1, 32'd4000000000);
		if (sel < 70)
			return $urandom_range(1000000, 400000000);
		return $urandom_range(1, 1000000);
	endfunction

	task random_phase(input int n);
		int unsigned wide_left;
		wide_left = 2;
		for (int i = 0; i < n; i++)
			send_request(pick_target(), pick_reference(wide_left));
	endtask

	// edges of the rate range, divider limits, zero reference, exact matches
	task directed_phase();
		send_request(32'd0, 32'd25000000);              // zero target
		send_request(32'd4000000001, 32'd25000000);     // just above 4 GHz
		send_request(32'hffffffff, 32'hffffffff);
		send_request(32'd4000000000, 32'd25000000);     // top valid target
		send_request(32'd3500000000, 32'd25000000);     // deskew holds divider at 1
		send_request(32'd3000000000, 32'd20000000);
		send_request(32'd1000000000, 32'd25000000);
		send_request(32'd1, 32'd25000000);              // largest vco divider
		send_request(32'd100000000, 32'd0);             // zero divided reference
		send_request(32'd100000000, 32'd1);
		send_request(32'd100000000, 32'd8000000);
		send_request(32'd100000000, 32'd32000000);      // 32 MHz band edge
		send_request(32'd100000000, 32'd32000001);
		send_request(32'd125000000, 32'd16000000);
		send_request(32'd148500000, 32'd27000000);
		send_request(32'd2, 32'd3);                     // offset toward minus one hundred
		send_request(32'd600000000, 32'hffffffff);      // longest walk, clamped divider
		send_request(32'd250000000, 32'd100000000);
	endtask

	initial begin
		repeat (2) @(negedge clk);
		arst_n = 1;
		directed_phase();
		set_deskew(1);
		directed_phase();
		random_phase(NUM_RANDOM / 3);
		set_deskew(0);
		random_phase(NUM_RANDOM / 3);
		set_deskew(1);
		random_phase(NUM_RANDOM / 6);
		set_deskew(0);
		random_phase(NUM_RANDOM / 6);
		@(negedge clk);
		start <= 0;
		while (board.pending.size() != 0)
			@(negedge clk);
		repeat (20) @(negedge clk);
		if (board.errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
